@@ rtl/core/frod_pkg.sv @@
// ----------------------------------------------------------------------------
// frod_pkg
// Shared types for the fetch range overlap detector: request and result
// payloads and the walk state encoding.
// ----------------------------------------------------------------------------
package frod_pkg;

	localparam int unsigned ADDR_W = 64;
	localparam int unsigned LEN_W  = 32;

	// request opcodes
	localparam logic OP_CHECK = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] fetch_address;
		logic [LEN_W-1:0]  fetch_length;
	} req_t;

	typedef struct packed {
		logic double_fetch;
		logic extended;
		logic dropped;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_WALK   = 3'b010,
		ST_FINISH = 3'b100
	} walk_state_t;

endpackage

@@ rtl/core/frod_range_mem.sv @@
// ----------------------------------------------------------------------------
// frod_range_mem
// Range table storage: start and end arrays, one write port with separate
// enables per array, one registered read port.
// ----------------------------------------------------------------------------
module frod_range_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned IDX_W = 4
) (
	input  logic             clk,
	input  logic             wr_start_en,
	input  logic             wr_end_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [63:0]      wr_start,
	input  logic [63:0]      wr_end,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [63:0]      rd_start,
	output logic [63:0]      rd_end
);
	import frod_pkg::*;

	logic [ADDR_W-1:0] start_mem [DEPTH];
	logic [ADDR_W-1:0] end_mem   [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_start_en) begin
			start_mem[wr_addr] <= wr_start;
		end
		if (wr_end_en) begin
			end_mem[wr_addr] <= wr_end;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_start <= start_mem[rd_addr];
			rd_end   <= end_mem[rd_addr];
		end
	end

endmodule

@@ rtl/core/frod_walk.sv @@
// ----------------------------------------------------------------------------
// frod_walk
// Walk sequencer: takes a request, walks stored ranges newest first through
// the range memory, extends or flags, stores new ranges and holds the result.
// ----------------------------------------------------------------------------
module frod_walk #(
	parameter int unsigned MAX_RANGES = 16,
	parameter int unsigned IDX_W      = 4,
	parameter int unsigned CNT_W      = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             check_disabled,
	input  logic             in_valid,
	output logic             in_stall,
	input  frod_pkg::req_t   in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output frod_pkg::rsp_t   out_data,
	output logic             wr_start_en,
	output logic             wr_end_en,
	output logic [IDX_W-1:0] wr_addr,
	output logic [63:0]      wr_start,
	output logic [63:0]      wr_end,
	output logic             rd_en,
	output logic [IDX_W-1:0] rd_addr,
	input  logic [63:0]      rd_start,
	input  logic [63:0]      rd_end
);
	import frod_pkg::*;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RANGES);

	walk_state_t       state_q;
	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;
	rsp_t              out_q;
	logic [ADDR_W-1:0] start_q;
	logic [ADDR_W-1:0] end_q;
	logic [IDX_W-1:0]  k_q;
	logic              op_q;
	logic              dis_q;
	logic              ext_q;
	logic              dbl_q;

	logic              accept;
	logic              fire;
	logic              plain_new;
	logic              store;
	logic              drop;
	logic              hit_ext;
	logic              hit_ovl;
	logic [ADDR_W-1:0] new_end;
	logic [CNT_W-1:0]  count_dec;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign new_end   = in_data.fetch_address + ADDR_W'(in_data.fetch_length);
	assign count_dec = count_q - CNT_W'(1);

	// compare the entry read last cycle against the request range
	assign hit_ext = (start_q == rd_end);
	assign hit_ovl = !((end_q < rd_start) || (start_q > rd_end));

	// finish: result slot free, then store or drop and present the result
	assign fire      = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
	assign plain_new = (op_q == OP_CHECK) && !dis_q && !dbl_q && !ext_q;
	assign store     = fire && plain_new && (count_q < CNT_MAX);
	assign drop      = fire && plain_new && (count_q >= CNT_MAX);

	// memory read address: newest entry on accept, then one step down per cycle
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = k_q - IDX_W'(1);
		if (state_q == ST_IDLE) begin
			rd_en   = accept;
			rd_addr = count_dec[IDX_W-1:0];
		end else if (state_q == ST_WALK) begin
			rd_en = (k_q != '0) && !(hit_ovl && !hit_ext);
		end
	end

	// memory write: extension during the walk, new range at finish
	always_comb begin
		wr_start_en = store;
		wr_end_en   = store || ((state_q == ST_WALK) && hit_ext);
		wr_addr     = store ? count_q[IDX_W-1:0] : k_q;
		wr_start    = start_q;
		wr_end      = end_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if ((in_data.op == OP_CHECK) && !check_disabled && (count_q != '0)) begin
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_WALK: begin
					if ((!hit_ext && hit_ovl) || (k_q == '0)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (fire && (op_q == OP_CLEAR)) begin
				count_q <= '0;
			end else if (store) begin
				count_q <= count_q + CNT_W'(1);
			end

			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request payload and walk flags
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= in_data.op;
			dis_q   <= check_disabled;
			start_q <= in_data.fetch_address;
			end_q   <= new_end;
			k_q     <= count_dec[IDX_W-1:0];
			ext_q   <= 1'b0;
			dbl_q   <= 1'b0;
		end else if (state_q == ST_WALK) begin
			if (hit_ext) begin
				ext_q <= 1'b1;
			end else if (hit_ovl) begin
				dbl_q <= 1'b1;
			end
			k_q <= k_q - IDX_W'(1);
		end
		if (fire) begin
			out_q.double_fetch <= dbl_q;
			out_q.extended     <= ext_q;
			out_q.dropped      <= drop;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ rtl/core/fetch_range_overlap_detector.sv @@
// ----------------------------------------------------------------------------
// fetch_range_overlap_detector
// Flags double fetches of user address ranges within one call.
//
// Request channel (in_valid / in_stall / in_data): op selects a range check
// or a clear of the table. A request is taken when in_valid is high and
// in_stall low. Result channel (out_valid / out_stall / out_data) carries
// double_fetch, extended and dropped, one result per request.
// Config channel (cfg_valid / cfg_ready / cfg_data) writes check_disabled;
// cfg_ready is always high, write only while no request is in flight.
// A check walks the stored ranges newest first, one per cycle through the
// range memory read port, visiting at most the stored count of ranges, and
// the result is registered when the walk ends. Clears, disabled checks and
// checks of an empty table skip the walk and go straight to the finish
// state. One request is in flight at a time; the next is taken only once
// the block is back in idle after the result is registered.
// A stalled result holds in the output register; the block keeps the
// finished request until that register frees, then takes the next one.
// Reset empties the table (count to zero) and clears check_disabled.
// ----------------------------------------------------------------------------
module fetch_range_overlap_detector #(
	parameter int unsigned MAX_RANGES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  frod_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output frod_pkg::rsp_t out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_data
);
	import frod_pkg::*;

	localparam int unsigned IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);

	logic              disabled_q;
	logic              wr_start_en;
	logic              wr_end_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [ADDR_W-1:0] wr_start;
	logic [ADDR_W-1:0] wr_end;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [ADDR_W-1:0] rd_start;
	logic [ADDR_W-1:0] rd_end;

	// check disable register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disabled_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			disabled_q <= cfg_data;
		end
	end

	// walk sequencer
	frod_walk #(
		.MAX_RANGES (MAX_RANGES),
		.IDX_W      (IDX_W),
		.CNT_W      (CNT_W)
	) u_walk (
		.clk            (clk),
		.arst_n         (arst_n),
		.check_disabled (disabled_q),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data),
		.wr_start_en    (wr_start_en),
		.wr_end_en      (wr_end_en),
		.wr_addr        (wr_addr),
		.wr_start       (wr_start),
		.wr_end         (wr_end),
		.rd_en          (rd_en),
		.rd_addr        (rd_addr),
		.rd_start       (rd_start),
		.rd_end         (rd_end)
	);

	// range table
	frod_range_mem #(
		.DEPTH (MAX_RANGES),
		.IDX_W (IDX_W)
	) u_mem (
		.clk         (clk),
		.wr_start_en (wr_start_en),
		.wr_end_en   (wr_end_en),
		.wr_addr     (wr_addr),
		.wr_start    (wr_start),
		.wr_end      (wr_end),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_start    (rd_start),
		.rd_end      (rd_end)
	);

endmodule

@@ rtl/core/frod_checker.sv @@
// ----------------------------------------------------------------------------
// frod_checker
// Port-level checks for the fetch range overlap detector, bound to the top.
// ----------------------------------------------------------------------------
module frod_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input frod_pkg::rsp_t out_data,
	input logic           cfg_valid,
	input logic           cfg_ready
);
	import frod_pkg::*;

	// a stalled result stays and holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// one request at a time: taking a request closes the request channel
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while another is in flight");

	// a double fetch stops the walk before anything is stored or dropped
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.double_fetch && out_data.dropped))
		else $error("double fetch and drop in one result");

	// an extended range means nothing new is stored, so nothing is dropped
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.extended && out_data.dropped))
		else $error("extension and drop in one result");

	// config is always accepted
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind fetch_range_overlap_detector frod_checker u_frod_checker (.*);
